// File: hw/rtl/tpf_pkg.sv
// ============================================================================
// tpf_pkg: shared types and constants of the test packet framer
// Frame layout constants, mode and register codes, FSM state type and the
// command and status groups between controller and datapath.
// ============================================================================
package tpf_pkg;

    // Frame geometry
    localparam int unsigned FRAME_BYTES = 28;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned HASHED_LEN  = 24;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] HASH_START = POS_W'(HASHED_LEN);

    // Fixed header bytes
    localparam logic [BYTE_W-1:0] MAGIC_0     = 8'h54;
    localparam logic [BYTE_W-1:0] MAGIC_1     = 8'h55;
    localparam logic [BYTE_W-1:0] MAGIC_2     = 8'h4D;
    localparam logic [BYTE_W-1:0] MAGIC_3     = 8'h31;
    localparam logic [BYTE_W-1:0] BAD_MAGIC   = 8'h58;
    localparam logic [BYTE_W-1:0] VERSION     = 8'h01;
    localparam logic [BYTE_W-1:0] LEN_BYTE    = BYTE_W'(FRAME_BYTES);
    localparam logic [BYTE_W-1:0] INVERT_MASK = 8'hFF;

    // Arithmetic constants
    localparam logic [WORD_W-1:0] HASH_BASIS  = 32'd2166136261;
    localparam logic [WORD_W-1:0] HASH_PRIME  = 32'd16777619;
    localparam logic [WORD_W-1:0] CHURN_MULT  = 32'd2654435761;
    localparam logic [WORD_W-1:0] JUMP_MULT   = 32'd1000;
    localparam int unsigned       GROUP_SHIFT = 3;   // divide by 8

    // Mode codes; 6 and 7 behave as spike
    typedef enum logic [MODE_W-1:0] {
        MODE_SPIKE     = 3'd0,
        MODE_REPLAY    = 3'd1,
        MODE_JUMP      = 3'd2,
        MODE_CHURN     = 3'd3,
        MODE_MALFORMED = 3'd4,
        MODE_DEAUTH    = 3'd5
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_RUN    = 2'd1,
        REG_SENDER = 2'd2
    } t_cfg_reg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PREP = 2'd1,
        ST_SEND = 2'd2
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture request fields
        logic prep;   // derive sender/sequence, seed hash
        logic adv;    // current byte taken, step to next
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;   // current byte is the final one
    } t_dp_stat;

endpackage

// File: hw/rtl/tpf_intf.sv
// ============================================================================
// tpf_intf: valid/ready channels of the test packet framer
// Request channel, frame byte channel and configuration write channel.
// ============================================================================
interface tpf_req_if;
    logic                          valid;
    logic                          ready;
    logic [tpf_pkg::WORD_W-1:0]    packet_ordinal;
    logic [tpf_pkg::WORD_W-1:0]    uptime_millis;

    modport source (output valid, output packet_ordinal, output uptime_millis,
                    input ready);
    modport sink   (input valid, input packet_ordinal, input uptime_millis,
                    output ready);
endinterface

interface tpf_byte_if;
    logic                          valid;
    logic                          ready;
    logic [tpf_pkg::BYTE_W-1:0]    frame_byte;
    logic [tpf_pkg::POS_W-1:0]     byte_position;
    logic                          last_byte;

    modport source (output valid, output frame_byte, output byte_position,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input last_byte, output ready);
endinterface

interface tpf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tpf_pkg::CFG_IDX_W-1:0] index;
    logic [tpf_pkg::WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/tpf_ctrl.sv
// ============================================================================
// tpf_ctrl: framer controller
// Sequences one request: capture, a preparation state, then 28 byte
// transfers. Drives the handshakes and issues datapath commands.
// ============================================================================
module tpf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_out_ready,
    input  tpf_pkg::t_dp_stat  i_stat,
    output logic               o_req_ready,
    output logic               o_out_valid,
    output tpf_pkg::t_dp_cmd   o_cmd
);
    import tpf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (i_out_ready && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ST_PREP: begin
                o_cmd.prep  = 1'b1;
            end
            ST_SEND: begin
                o_out_valid = 1'b1;
                o_cmd.adv   = i_out_ready;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/tpf_dp.sv
// ============================================================================
// tpf_dp: framer datapath
// Configuration registers, request capture, sender/sequence derivation,
// byte selection and the FNV-1a hash, one byte per transfer over bytes 0-23.
// ============================================================================
module tpf_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tpf_pkg::t_dp_cmd                i_cmd,
    output tpf_pkg::t_dp_stat               o_stat,
    input  logic                            i_cfg_we,
    input  logic [tpf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpf_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic [tpf_pkg::WORD_W-1:0]      i_ordinal,
    input  logic [tpf_pkg::WORD_W-1:0]      i_uptime,
    output logic [tpf_pkg::BYTE_W-1:0]      o_frame_byte,
    output logic [tpf_pkg::POS_W-1:0]       o_byte_position,
    output logic                            o_last_byte
);
    import tpf_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [WORD_W-1:0] r_run;
    logic [WORD_W-1:0] r_base;

    logic [WORD_W-1:0] r_ord;
    logic [WORD_W-1:0] r_up;
    logic [WORD_W-1:0] r_seq;
    logic [WORD_W-1:0] r_sender;
    logic [WORD_W-1:0] r_hash;
    logic [POS_W-1:0]  r_pos;
    logic              r_bad_magic;
    logic              r_bad_check;

    logic [WORD_W-1:0] n_seq;
    logic [WORD_W-1:0] n_sender;
    logic [WORD_W-1:0] n_hash;
    logic [BYTE_W-1:0] raw_byte;
    logic [WORD_W-1:0] word_sel;
    logic              malformed;

    // Configuration registers; out-of-range index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_run  <= '0;
            r_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:   r_mode <= i_cfg_data[MODE_W-1:0];
                REG_RUN:    r_run  <= i_cfg_data;
                REG_SENDER: r_base <= i_cfg_data;
                default:    r_mode <= r_mode;
            endcase
        end
    end

    assign malformed = (r_mode == MODE_MALFORMED);

    // Sender and sequence words from the captured ordinal
    always_comb begin
        n_seq    = r_ord;
        n_sender = r_base;
        case (r_mode)
            MODE_REPLAY: n_seq    = r_ord >> GROUP_SHIFT;
            MODE_JUMP:   n_seq    = WORD_W'(r_ord * JUMP_MULT);
            MODE_CHURN:  n_sender = r_base ^ WORD_W'((r_ord >> GROUP_SHIFT) * CHURN_MULT);
            default:     n_seq    = r_ord;
        endcase
    end

    // Unaltered frame byte at the current position
    always_comb begin
        case (r_pos[POS_W-1:2])
            3'd2:    word_sel = r_run;
            3'd3:    word_sel = r_sender;
            3'd4:    word_sel = r_seq;
            3'd5:    word_sel = r_up;
            default: word_sel = r_hash;
        endcase
        case (r_pos)
            5'd0:    raw_byte = MAGIC_0;
            5'd1:    raw_byte = MAGIC_1;
            5'd2:    raw_byte = MAGIC_2;
            5'd3:    raw_byte = MAGIC_3;
            5'd4:    raw_byte = VERSION;
            5'd5:    raw_byte = BYTE_W'(r_mode);
            5'd6:    raw_byte = BYTE_W'(malformed);
            5'd7:    raw_byte = LEN_BYTE;
            default: begin
                // big-endian: offset 0 within the word is the top byte
                case (r_pos[1:0])
                    2'd0:    raw_byte = word_sel[31:24];
                    2'd1:    raw_byte = word_sel[23:16];
                    2'd2:    raw_byte = word_sel[15:8];
                    default: raw_byte = word_sel[7:0];
                endcase
            end
        endcase
    end

    // Hash step over the unaltered byte
    assign n_hash = WORD_W'((r_hash ^ WORD_W'(raw_byte)) * HASH_PRIME);

    // Request capture, preparation and per-byte stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ord <= i_ordinal;
            r_up  <= i_uptime;
        end
        if (i_cmd.prep) begin
            r_seq       <= n_seq;
            r_sender    <= n_sender;
            r_hash      <= HASH_BASIS;
            r_pos       <= '0;
            r_bad_magic <= malformed && !r_ord[0];
            r_bad_check <= malformed && r_ord[0];
        end
        if (i_cmd.adv) begin
            r_pos <= r_pos + POS_W'(1);
            if (r_pos < HASH_START) begin
                r_hash <= n_hash;
            end
        end
    end

    // Output byte with the malformed alterations
    always_comb begin
        o_frame_byte = raw_byte;
        if (r_pos == '0 && r_bad_magic) begin
            o_frame_byte = BAD_MAGIC;
        end else if (r_pos == LAST_POS && r_bad_check) begin
            o_frame_byte = raw_byte ^ INVERT_MASK;
        end
    end

    assign o_byte_position = r_pos;
    assign o_last_byte     = (r_pos == LAST_POS);
    assign o_stat.last     = (r_pos == LAST_POS);

endmodule

// File: hw/rtl/test_packet_framer.sv
// ============================================================================
// test_packet_framer: per-request 28-byte test frame generator
// Builds a header, four big-endian words and an FNV-1a 32 trailer and sends
// the frame one byte per transfer.
// ============================================================================
// First byte: valid in the send state, which follows the preparation state
// after capture. Bytes go out at one per cycle while the sink is ready; a sink
// stall holds the current byte. A new request is taken only after the last
// byte: capture, then preparation, then 28 byte transfers.
// Reset (i_rst_n low, synchronous): controller idle, configuration registers cleared to 0.
module test_packet_framer (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tpf_req_if.sink    i_req,
    tpf_byte_if.source o_byte,
    tpf_cfg_if.sink    i_cfg
);
    import tpf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    tpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_out_ready (o_byte.ready),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_out_valid (o_byte.valid),
        .o_cmd       (cmd)
    );

    tpf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_ordinal       (i_req.packet_ordinal),
        .i_uptime        (i_req.uptime_millis),
        .o_frame_byte    (o_byte.frame_byte),
        .o_byte_position (o_byte.byte_position),
        .o_last_byte     (o_byte.last_byte)
    );

    // Never take a request while a frame is being sent
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_byte.valid))
        else $error("request accepted during frame");

    // Bytes follow in order without gaps
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.ready && !o_byte.last_byte) |=>
        (o_byte.valid && o_byte.byte_position == $past(o_byte.byte_position) + 5'd1))
        else $error("byte position skipped");

    // A new frame starts at offset zero after the preparation cycle
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> ##1 (o_byte.valid && o_byte.byte_position == 5'd0))
        else $error("frame did not start at byte zero");

    // After the final byte the block is ready for the next request
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.ready && o_byte.last_byte) |=> (i_req.ready && !o_byte.valid))
        else $error("not idle after final byte");

endmodule

// File: test/test_packet_framer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// test_packet_framer_tb: self-checking bench for the test packet framer
// Sends frame requests under several register settings, works out every
// frame byte in a local predictor and checks each byte from the block in
// order. Both sides idle at random; the receiver also holds off once for a
// long stretch so that the block backs up onto its request input.
// ============================================================================
module test_packet_framer_tb;
    import tpf_pkg::*;

    // Frame contents, kept independent of the RTL package
    localparam logic [7:0]  EXP_MAGIC_0   = 8'h54;
    localparam logic [7:0]  EXP_MAGIC_1   = 8'h55;
    localparam logic [7:0]  EXP_MAGIC_2   = 8'h4D;
    localparam logic [7:0]  EXP_MAGIC_3   = 8'h31;
    localparam logic [7:0]  EXP_VERSION   = 8'h01;
    localparam logic [7:0]  EXP_BAD_MAGIC = 8'h58;
    localparam int          EXP_LEN       = 28;
    localparam int          EXP_HASHED    = 24;
    localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME     = 32'd16777619;
    localparam logic [31:0] CHURN_FACTOR  = 32'd2654435761;
    localparam logic [31:0] JUMP_FACTOR   = 32'd1000;

    // Codes outside the package enums
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_RSVD7 = 3'd7;

    localparam int HOLD_AFTER   = 800;   // bytes taken before the long hold-off
    localparam int HOLD_LEN     = 300;
    localparam int SETTLE       = 16;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_ITEMS  = 10;

    typedef struct {
        logic [31:0] ordinal;
        logic [31:0] uptime;
    } t_frame_req;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_frame_slot;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tpf_req_if  req_ch();
    tpf_byte_if byte_ch();
    tpf_cfg_if  cfg_ch();

    test_packet_framer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_byte  (byte_ch),
        .i_cfg   (cfg_ch)
    );

    // Local copy of the registers
    logic [MODE_W-1:0] cfg_mode;
    logic [31:0]       cfg_run;
    logic [31:0]       cfg_sender;

    t_frame_req  requests_pending[$];
    t_frame_slot frame_bytes_due[$];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int bytes_taken;
    int hold_left;
    bit hold_done;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Expected 28 bytes of the frame for one request
    function automatic void predict_frame(input logic [31:0] ordinal,
                                          input logic [31:0] uptime);
        logic [7:0]   fr [0:EXP_LEN-1];
        logic [31:0]  seq;
        logic [31:0]  sender;
        logic [31:0]  fnv;
        logic [127:0] words;
        bit           bad_magic;
        bit           bad_check;
        t_frame_slot  slot;
        seq       = ordinal;
        sender    = cfg_sender;
        bad_magic = 1'b0;
        bad_check = 1'b0;
        case (cfg_mode)
            MODE_REPLAY:    seq = ordinal >> 3;
            MODE_JUMP:      seq = ordinal * JUMP_FACTOR;
            MODE_CHURN:     sender = cfg_sender ^ ((ordinal >> 3) * CHURN_FACTOR);
            MODE_MALFORMED: begin
                bad_magic = ~ordinal[0];
                bad_check = ordinal[0];
            end
            default: ;
        endcase
        fr[0] = EXP_MAGIC_0;
        fr[1] = EXP_MAGIC_1;
        fr[2] = EXP_MAGIC_2;
        fr[3] = EXP_MAGIC_3;
        fr[4] = EXP_VERSION;
        fr[5] = {5'd0, cfg_mode};
        fr[6] = (bad_magic || bad_check) ? 8'd1 : 8'd0;
        fr[7] = 8'(EXP_LEN);
        words = {cfg_run, sender, seq, uptime};
        for (int k = 0; k < 16; k++) fr[8 + k] = words[127 - 8 * k -: 8];
        // FNV-1a over the header and words
        fnv = FNV_BASIS;
        for (int k = 0; k < EXP_HASHED; k++) begin
            fnv = fnv ^ {24'd0, fr[k]};
            fnv = fnv * FNV_PRIME;
        end
        for (int k = 0; k < 4; k++) fr[EXP_HASHED + k] = fnv[31 - 8 * k -: 8];
        // malformed alterations come after hashing
        if (bad_magic) fr[0] = EXP_BAD_MAGIC;
        if (bad_check) fr[EXP_LEN - 1] = ~fr[EXP_LEN - 1];
        for (int k = 0; k < EXP_LEN; k++) begin
            slot.data = fr[k];
            slot.pos  = POS_W'(k);
            slot.last = (k == EXP_LEN - 1);
            frame_bytes_due.push_back(slot);
        end
    endfunction

    // Request driver: prediction made on the accepting edge
    always @(posedge i_clk) begin : req_driver
        t_frame_req nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                predict_frame(req_ch.packet_ordinal, req_ch.uptime_millis);
            if (!req_ch.valid || req_ch.ready) begin
                if (requests_pending.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = requests_pending.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.packet_ordinal <= nxt.ordinal;
                    req_ch.uptime_millis  <= nxt.uptime;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            byte_ch.ready <= 1'b0;
        else
            byte_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Byte monitor and checker
    always @(posedge i_clk) begin : byte_monitor
        t_frame_slot want;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            bytes_taken <= bytes_taken + 1;
            if (frame_bytes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte: expected none, got data %h pos %0d last %b",
                         $time, byte_ch.frame_byte, byte_ch.byte_position,
                         byte_ch.last_byte);
            end else begin
                want = frame_bytes_due.pop_front();
                if (byte_ch.frame_byte !== want.data) begin
                    errors++;
                    $display("%0t: byte %0d data: expected %h, got %h",
                             $time, want.pos, want.data, byte_ch.frame_byte);
                end
                if (byte_ch.byte_position !== want.pos) begin
                    errors++;
                    $display("%0t: position: expected %0d, got %0d",
                             $time, want.pos, byte_ch.byte_position);
                end
                if (byte_ch.last_byte !== want.last) begin
                    errors++;
                    $display("%0t: byte %0d last flag: expected %b, got %b",
                             $time, want.pos, want.last, byte_ch.last_byte);
                end
            end
        end
    end

    // Leaves the channel high on the accepting edge; caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_MODE:   cfg_mode   = val[MODE_W-1:0];
            REG_RUN:    cfg_run    = val;
            REG_SENDER: cfg_sender = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [MODE_W-1:0] mode, input logic [31:0] run,
                                input logic [31:0] sender);
        // upper data bits of the mode write carry noise
        write_reg(REG_MODE, ($urandom() & ~32'h7) | {29'd0, mode});
        write_reg(REG_RUN, run);
        write_reg(REG_SENDER, sender);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (requests_pending.size() != 0 || req_ch.valid || frame_bytes_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_request(input logic [31:0] ordinal, input logic [31:0] uptime);
        t_frame_req r;
        r.ordinal = ordinal;
        r.uptime  = uptime;
        requests_pending.push_back(r);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 63);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
            default: return $urandom();
        endcase
    endfunction

    // Sequencer
    initial begin : sequencer
        logic [MODE_W-1:0] mode;
        req_ch.valid          = 1'b0;
        req_ch.packet_ordinal = '0;
        req_ch.uptime_millis  = '0;
        byte_ch.ready         = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        i_rst_n               = 1'b0;
        cfg_mode              = MODE_SPIKE;
        cfg_run               = '0;
        cfg_sender            = '0;
        errors                = 0;
        bytes_taken           = 0;
        send_idle_pct         = 22;
        recv_idle_pct         = 52;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, field extremes
        add_request(32'h0000_0000, 32'h0000_0000);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(32'h0000_0001, 32'h55AA_33CC);
        wait_idle();

        // Out-of-range index must be ignored; churn with all-ones ids
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        program_regs(MODE_CHURN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(32'hFFFF_FFFF, $urandom());
        add_request(32'd8, $urandom());
        add_request(32'd7, $urandom());
        wait_idle();

        // Replay group boundary
        program_regs(MODE_REPLAY, $urandom(), $urandom());
        add_request(32'd7, $urandom());
        add_request(32'd8, $urandom());
        wait_idle();

        // Jump wrap-round
        program_regs(MODE_JUMP, $urandom(), $urandom());
        add_request(32'hFFFF_FFFF, $urandom());
        add_request(32'd4294968, $urandom());
        wait_idle();

        // Malformed: even ordinal spoils the magic, odd the checksum
        program_regs(MODE_MALFORMED, $urandom(), $urandom());
        add_request(32'd0, $urandom());
        add_request(32'd1, $urandom());
        add_request(32'hFFFF_FFFE, $urandom());
        wait_idle();

        program_regs(MODE_DEAUTH, $urandom(), $urandom());
        add_request(32'd5, $urandom());
        wait_idle();

        // Undefined mode codes behave as spike
        program_regs(MODE_RSVD6, $urandom(), $urandom());
        add_request($urandom(), $urandom());
        wait_idle();
        program_regs(MODE_RSVD7, $urandom(), $urandom());
        add_request($urandom(), $urandom());
        wait_idle();

        program_regs(MODE_SPIKE, 32'h0, 32'h0);
        add_request(32'd12345, $urandom());
        wait_idle();

        // Random phases: idle profile shifts as the run goes on
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 52;
            end else if (p < 6) begin
                send_idle_pct = 52;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mode = ($urandom_range(0, 7) == 0) ? MODE_W'($urandom_range(6, 7))
                                               : MODE_W'($urandom_range(0, 5));
            program_regs(mode, pick_word(), pick_word());
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_request(pick_word(), $urandom());
            wait_idle();
        end

        if (errors == 0)
            $display("PASS test_packet_framer");
        else
            $display("FAIL test_packet_framer");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL test_packet_framer");
        $finish;
    end

endmodule
